>>> design/mog_pkg.sv
// Shared types, codes and a helper function for the motion oscillation guard.
`timescale 1ns / 1ps
`default_nettype none

package mog_pkg;

    // Action codes carried by an input transaction.
    localparam logic [1:0] ACT_SCORE  = 2'd0;
    localparam logic [1:0] ACT_COMMIT = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLOW_SPEED     = 2'd0;
    localparam logic [1:0] CFG_RESET_DISTANCE = 2'd1;
    localparam logic [1:0] CFG_RESET_ANGLE    = 2'd2;

    // Configuration reset values.
    localparam int unsigned SLOW_SPEED_RST      = 410;
    localparam int unsigned RESET_RADIUS_RST    = 205;
    localparam int unsigned RESET_ANGLE_RST     = 819;
    localparam logic [39:0] RESET_RADIUS_SQ_RST = 40'(RESET_RADIUS_RST * RESET_RADIUS_RST);

    // Cost reported for a candidate that breaks a latched restriction.
    localparam logic signed [3:0] COST_PENALTY = -4'sd5;
    localparam logic signed [3:0] COST_NONE    = 4'sd0;

    // One input transaction.
    typedef struct packed {
        logic [1:0]          action;
        logic signed [15:0]  vel_fwd;
        logic signed [15:0]  vel_side;
        logic signed [15:0]  vel_turn;
        logic                traj_valid;
        logic signed [23:0]  pose_x;
        logic signed [23:0]  pose_y;
        logic signed [15:0]  pose_yaw;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [3:0] cost;
        logic              oscillation_found;
        logic [5:0]        restrictions;
    } result_t;

    // Direction history, restriction flags and the stored anchor pose.
    // Bit order of seen and flags: fwd+, fwd-, side+, side-, turn+, turn-.
    typedef struct packed {
        logic [5:0]         seen;
        logic [5:0]         flags;
        logic signed [23:0] anchor_x;
        logic signed [23:0] anchor_y;
        logic signed [15:0] anchor_yaw;
    } guard_state_t;

    // Configuration as the step logic uses it; the distance is kept squared.
    typedef struct packed {
        logic [14:0] slow_speed;
        logic [14:0] reset_angle;
        logic [39:0] reset_radius_sq;
    } guard_cfg_t;

    // Outcome of one axis update: bit 0 is the positive direction.
    typedef struct packed {
        logic [1:0] seen;
        logic [1:0] set;
        logic       hit;
    } axis_t;

    // A reversal against the last seen direction latches the new direction only.
    function automatic axis_t axis_update(input logic [1:0] seen,
                                          input logic neg,
                                          input logic pos);
        axis_t r;
        r.seen = seen;
        r.set  = 2'b00;
        r.hit  = 1'b0;
        if (neg)
        begin
            r.hit  = seen[0];
            r.set  = {seen[0], 1'b0};
            r.seen = 2'b10;
        end
        else if (pos)
        begin
            r.hit  = seen[1];
            r.set  = {1'b0, seen[1]};
            r.seen = 2'b01;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/mog_step.sv
// Single-pass step logic: scores, commits or clears one transaction against the guard state.
`timescale 1ns / 1ps
`default_nettype none

module mog_step (
    input  wire mog_pkg::item_t        item,
    input  wire mog_pkg::guard_state_t state_cur,
    input  wire mog_pkg::guard_cfg_t   cfg,
    output mog_pkg::guard_state_t      state_next,
    output mog_pkg::result_t           result
);

    logic              fwd_neg;
    logic              fwd_pos;
    logic              side_neg;
    logic              side_pos;
    logic              turn_neg;
    logic              turn_pos;
    logic [15:0]       fwd_abs;
    logic              slow;
    mog_pkg::axis_t    fwd_ax;
    mog_pkg::axis_t    side_ax;
    mog_pkg::axis_t    turn_ax;
    logic [5:0]        seen_cmt;
    logic [5:0]        flags_cmt;
    logic              hit;
    logic              violation;
    logic signed [24:0] dx_s;
    logic signed [24:0] dy_s;
    logic signed [16:0] dyaw_s;
    logic [23:0]       dx_abs;
    logic [23:0]       dy_abs;
    logic [15:0]       dyaw_abs;
    logic [47:0]       dx_sq;
    logic [47:0]       dy_sq;
    logic [48:0]       offset_sq;
    logic              far;

    // Sign of each velocity; zero moves neither way.
    assign fwd_neg  = item.vel_fwd[15];
    assign fwd_pos  = !item.vel_fwd[15] && (item.vel_fwd != 16'sd0);
    assign side_neg = item.vel_side[15];
    assign side_pos = !item.vel_side[15] && (item.vel_side != 16'sd0);
    assign turn_neg = item.vel_turn[15];
    assign turn_pos = !item.vel_turn[15] && (item.vel_turn != 16'sd0);

    // Sideways and turn history only moves at low forward speed.
    assign fwd_abs = fwd_neg ? $unsigned(16'(-item.vel_fwd)) : $unsigned(item.vel_fwd);
    assign slow    = fwd_abs <= {1'b0, cfg.slow_speed};

    // Per-axis history update for a commit.
    assign fwd_ax  = mog_pkg::axis_update(state_cur.seen[1:0], fwd_neg, fwd_pos);
    assign side_ax = mog_pkg::axis_update(state_cur.seen[3:2], side_neg, side_pos);
    assign turn_ax = mog_pkg::axis_update(state_cur.seen[5:4], turn_neg, turn_pos);

    assign seen_cmt  = slow ? {turn_ax.seen, side_ax.seen, fwd_ax.seen}
                            : {state_cur.seen[5:2], fwd_ax.seen};
    assign flags_cmt = state_cur.flags
                     | (slow ? {turn_ax.set, side_ax.set, fwd_ax.set}
                             : {4'b0000, fwd_ax.set});
    assign hit       = fwd_ax.hit || (slow && (side_ax.hit || turn_ax.hit));

    // Distance and yaw change from the stored anchor. A hit moves the anchor
    // to the current pose, so the test only matters when there is no hit.
    assign dx_s      = 25'(item.pose_x) - 25'(state_cur.anchor_x);
    assign dy_s      = 25'(item.pose_y) - 25'(state_cur.anchor_y);
    assign dyaw_s    = 17'(item.pose_yaw) - 17'(state_cur.anchor_yaw);
    assign dx_abs    = dx_s[24] ? 24'(-dx_s) : dx_s[23:0];
    assign dy_abs    = dy_s[24] ? 24'(-dy_s) : dy_s[23:0];
    assign dyaw_abs  = dyaw_s[16] ? 16'(-dyaw_s) : dyaw_s[15:0];
    assign dx_sq     = dx_abs * dx_abs;
    assign dy_sq     = dy_abs * dy_abs;
    assign offset_sq = 49'(dx_sq) + 49'(dy_sq);
    assign far       = (offset_sq > 49'(cfg.reset_radius_sq))
                    || (dyaw_abs > {1'b0, cfg.reset_angle});

    // Candidate breaks a latched one-direction restriction.
    assign violation = (state_cur.flags[0] && fwd_neg)  || (state_cur.flags[1] && fwd_pos)
                    || (state_cur.flags[2] && side_neg) || (state_cur.flags[3] && side_pos)
                    || (state_cur.flags[4] && turn_neg) || (state_cur.flags[5] && turn_pos);

    // Action decode and state update.
    always_comb
    begin
        state_next                = state_cur;
        result.cost               = mog_pkg::COST_NONE;
        result.oscillation_found  = 1'b0;
        case (item.action)
            mog_pkg::ACT_SCORE:
            begin
                if (violation)
                begin
                    result.cost = mog_pkg::COST_PENALTY;
                end
            end
            mog_pkg::ACT_COMMIT:
            begin
                if (item.traj_valid)
                begin
                    state_next.seen  = seen_cmt;
                    state_next.flags = flags_cmt;
                    if (hit)
                    begin
                        result.oscillation_found = 1'b1;
                        state_next.anchor_x      = item.pose_x;
                        state_next.anchor_y      = item.pose_y;
                        state_next.anchor_yaw    = item.pose_yaw;
                    end
                    else if ((flags_cmt != 6'd0) && far)
                    begin
                        state_next.seen  = 6'd0;
                        state_next.flags = 6'd0;
                    end
                end
            end
            mog_pkg::ACT_CLEAR:
            begin
                state_next.seen  = 6'd0;
                state_next.flags = 6'd0;
            end
            default:
            begin
            end
        endcase
        result.restrictions = state_next.flags;
    end

endmodule

`default_nettype wire

>>> design/motion_oscillation_guard_top.sv
// Top level of the motion oscillation guard: channels, configuration and state registers.
`timescale 1ns / 1ps
`default_nettype none

// The guard takes one transaction per clock while the output is not stalled and
// returns exactly one result per transaction, through the input register and then
// the result register. Guard state (direction history, restriction flags, anchor
// pose) is updated in the same cycle that a transaction moves from the input
// register to the result register, so consecutive transactions see each other's
// effects with no gap. The cycle time is set by the commit path: two 24 by 24 bit
// squares of the pose offset, their sum and a compare against the squared reset
// distance. The reset distance is squared when it is written, and configuration
// writes reach the step logic in the cycle after the write; write configuration
// only while the block is idle.
module motion_oscillation_guard_top (
    input  wire               clk,
    input  wire               rst_n,
    // Input channel
    input  wire               in_valid,
    output logic              in_stall,
    input  wire [1:0]         action,
    input  wire signed [15:0] vel_fwd,
    input  wire signed [15:0] vel_side,
    input  wire signed [15:0] vel_turn,
    input  wire               traj_valid,
    input  wire signed [23:0] pose_x,
    input  wire signed [23:0] pose_y,
    input  wire signed [15:0] pose_yaw,
    // Output channel
    output logic              out_valid,
    input  wire               out_stall,
    output logic signed [3:0] cost,
    output logic              oscillation_found,
    output logic [5:0]        restrictions,
    // Configuration port
    input  wire               cfg_write,
    input  wire [1:0]         cfg_index,
    input  wire [19:0]        cfg_data
);

    logic                  in_accept;
    logic                  advance;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    mog_pkg::item_t        s1_item_reg;
    mog_pkg::item_t        s1_item_next;
    mog_pkg::item_t        in_item;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    mog_pkg::result_t      out_res_reg;
    mog_pkg::result_t      out_res_next;
    mog_pkg::result_t      step_res;
    mog_pkg::guard_state_t state_reg;
    mog_pkg::guard_state_t state_next;
    mog_pkg::guard_state_t step_state;
    mog_pkg::guard_cfg_t   cfg_reg;
    mog_pkg::guard_cfg_t   cfg_next;
    logic [19:0]           radius_wr;
    logic [39:0]           radius_wr_sq;

    // Handshake: the input register moves on whenever the result register is
    // empty or being drained this cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign in_item.action     = action;
    assign in_item.vel_fwd    = vel_fwd;
    assign in_item.vel_side   = vel_side;
    assign in_item.vel_turn   = vel_turn;
    assign in_item.traj_valid = traj_valid;
    assign in_item.pose_x     = pose_x;
    assign in_item.pose_y     = pose_y;
    assign in_item.pose_yaw   = pose_yaw;

    // Step logic between the input register and the result register.
    mog_step u_step (
        .item       (s1_item_reg),
        .state_cur  (state_reg),
        .cfg        (cfg_reg),
        .state_next (step_state),
        .result     (step_res)
    );

    // Next values for the pipeline and the guard state.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        state_next     = state_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_item_next  = in_item;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_res_next   = step_res;
            state_next     = step_state;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration writes; the reset distance is stored squared.
    assign radius_wr    = cfg_data;
    assign radius_wr_sq = radius_wr * radius_wr;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mog_pkg::CFG_SLOW_SPEED:     cfg_next.slow_speed      = cfg_data[14:0];
                mog_pkg::CFG_RESET_DISTANCE: cfg_next.reset_radius_sq = radius_wr_sq;
                mog_pkg::CFG_RESET_ANGLE:    cfg_next.reset_angle     = cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control, state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg               <= '0;
            cfg_reg.slow_speed      <= 15'(mog_pkg::SLOW_SPEED_RST);
            cfg_reg.reset_angle     <= 15'(mog_pkg::RESET_ANGLE_RST);
            cfg_reg.reset_radius_sq <= mog_pkg::RESET_RADIUS_SQ_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid         = out_valid_reg;
    assign cost              = out_res_reg.cost;
    assign oscillation_found = out_res_reg.oscillation_found;
    assign restrictions      = out_res_reg.restrictions;

endmodule

`default_nettype wire

>>> design/mog_checker.sv
// Port-level assertions for the motion oscillation guard, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mog_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              out_valid,
    input wire              out_stall,
    input wire signed [3:0] cost,
    input wire              oscillation_found,
    input wire [5:0]        restrictions
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cost)
            && $stable(oscillation_found) && $stable(restrictions))
        else $error("stalled result transaction changed");

    // Cost is either the penalty or zero.
    a_cost_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cost == -4'sd5) || (cost == 4'sd0))
        else $error("cost outside its two codes");

    // Only a score carries a cost, and a score never reports a new latch.
    a_cost_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cost != 4'sd0) |-> !oscillation_found)
        else $error("penalty and new latch in one result");

    // A penalty needs a restriction to break.
    a_cost_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cost != 4'sd0) |-> (restrictions != 6'd0))
        else $error("penalty with no restriction held");

    // A new latch leaves at least one restriction held.
    a_found_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && oscillation_found |-> (restrictions != 6'd0))
        else $error("new latch with no restriction held");

endmodule

bind motion_oscillation_guard_top mog_checker u_mog_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cost              (cost),
    .oscillation_found (oscillation_found),
    .restrictions      (restrictions)
);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the motion oscillation guard top level.
`timescale 1ns / 1ps

module testbench;

    // Action code with no meaning to the guard; it must leave all state alone.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Input channel.
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = mog_pkg::ACT_SCORE;
    logic signed [15:0] vel_fwd = '0;
    logic signed [15:0] vel_side = '0;
    logic signed [15:0] vel_turn = '0;
    logic               traj_valid = 1'b0;
    logic signed [23:0] pose_x = '0;
    logic signed [23:0] pose_y = '0;
    logic signed [15:0] pose_yaw = '0;

    // Output channel.
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [3:0]  cost;
    logic               oscillation_found;
    logic [5:0]         restrictions;

    // Configuration port.
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = mog_pkg::CFG_SLOW_SPEED;
    logic [19:0]        cfg_data = '0;

    // Guard model state, in the bit order of restrictions.
    logic [5:0]         dir_seen = '0;
    logic [5:0]         dir_only = '0;
    logic signed [23:0] anchor_px = '0;
    logic signed [23:0] anchor_py = '0;
    logic signed [15:0] anchor_pyaw = '0;
    logic [14:0]        gate_speed = 15'(mog_pkg::SLOW_SPEED_RST);
    logic [19:0]        clear_radius = 20'(mog_pkg::RESET_RADIUS_RST);
    logic [14:0]        clear_yaw = 15'(mog_pkg::RESET_ANGLE_RST);

    // Verdicts predicted for accepted transactions, oldest first.
    mog_pkg::result_t pending_verdicts[$];

    int error_count = 0;
    int items_taken = 0;
    int results_seen = 0;
    int latch_count = 0;
    int penalty_count = 0;
    int settings_used = 1;
    int cycle_count = 0;

    // Sender pacing and receiver stall controls.
    int burst_left = 0;
    int gap_max = 8;
    bit stall_enable = 1'b1;
    int stall_mode = 0;
    int stall_phase_left = 0;
    int stall_tick = 0;
    int stall_hold = 0;

    // Pose that the robot walks along during random commits.
    int walk_x = 0;
    int walk_y = 0;
    int walk_yaw = 0;

    motion_oscillation_guard_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .vel_fwd           (vel_fwd),
        .vel_side          (vel_side),
        .vel_turn          (vel_turn),
        .traj_valid        (traj_valid),
        .pose_x            (pose_x),
        .pose_y            (pose_y),
        .pose_yaw          (pose_yaw),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .cost              (cost),
        .oscillation_found (oscillation_found),
        .restrictions      (restrictions),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver backpressure: a random stall pattern is chosen for each phase.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(40, 250);
        end
        else
        begin
            stall_phase_left = stall_phase_left - 1;
        end
        stall_tick = stall_tick + 1;
        if (!stall_enable)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                1: out_stall <= ($urandom_range(0, 2) == 0);
                2: out_stall <= ((stall_tick % 8) < 3);
                3:
                begin
                    if (stall_hold > 0)
                    begin
                        stall_hold = stall_hold - 1;
                        out_stall <= 1'b1;
                    end
                    else
                    begin
                        if ($urandom_range(0, 7) == 0)
                            stall_hold = $urandom_range(2, 10);
                        out_stall <= 1'b0;
                    end
                end
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // One mismatch line; the count keeps going after the print limit.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        error_count = error_count + 1;
    endtask

    // Updates the history of one axis; returns 1 when a reversal latches a flag.
    function automatic logic track_axis(input logic signed [15:0] v, input int pos_bit);
        logic latched;
        latched = 1'b0;
        if (v < 0)
        begin
            if (dir_seen[pos_bit])
            begin
                dir_only[pos_bit + 1] = 1'b1;
                latched = 1'b1;
            end
            dir_seen[pos_bit] = 1'b0;
            dir_seen[pos_bit + 1] = 1'b1;
        end
        else if (v > 0)
        begin
            if (dir_seen[pos_bit + 1])
            begin
                dir_only[pos_bit] = 1'b1;
                latched = 1'b1;
            end
            dir_seen[pos_bit + 1] = 1'b0;
            dir_seen[pos_bit] = 1'b1;
        end
        return latched;
    endfunction

    // Applies one transaction to the guard model and returns its verdict.
    function automatic mog_pkg::result_t guard_verdict(input mog_pkg::item_t it);
        mog_pkg::result_t r;
        logic hit;
        int fwd_mag;
        longint dx;
        longint dy;
        longint dyaw;
        longint offset_sq;
        longint limit_sq;
        r.cost = mog_pkg::COST_NONE;
        r.oscillation_found = 1'b0;
        case (it.action)
            mog_pkg::ACT_SCORE:
            begin
                if ((dir_only[0] && it.vel_fwd < 0) || (dir_only[1] && it.vel_fwd > 0) ||
                    (dir_only[2] && it.vel_side < 0) || (dir_only[3] && it.vel_side > 0) ||
                    (dir_only[4] && it.vel_turn < 0) || (dir_only[5] && it.vel_turn > 0))
                    r.cost = mog_pkg::COST_PENALTY;
            end
            mog_pkg::ACT_COMMIT:
            begin
                if (it.traj_valid)
                begin
                    hit = track_axis(it.vel_fwd, 0);
                    fwd_mag = it.vel_fwd;
                    if (fwd_mag < 0)
                        fwd_mag = -fwd_mag;
                    // Sideways and turn history only moves while nearly stopped.
                    if (fwd_mag <= int'(gate_speed))
                    begin
                        if (track_axis(it.vel_side, 2))
                            hit = 1'b1;
                        if (track_axis(it.vel_turn, 4))
                            hit = 1'b1;
                    end
                    if (hit)
                    begin
                        r.oscillation_found = 1'b1;
                        anchor_px = it.pose_x;
                        anchor_py = it.pose_y;
                        anchor_pyaw = it.pose_yaw;
                    end
                    // Leaving the anchor neighborhood releases every restriction.
                    if (dir_only != 6'd0)
                    begin
                        dx = longint'(it.pose_x) - longint'(anchor_px);
                        dy = longint'(it.pose_y) - longint'(anchor_py);
                        dyaw = longint'(it.pose_yaw) - longint'(anchor_pyaw);
                        if (dyaw < 0)
                            dyaw = -dyaw;
                        offset_sq = dx * dx + dy * dy;
                        limit_sq = longint'(clear_radius);
                        limit_sq = limit_sq * limit_sq;
                        if (offset_sq > limit_sq || dyaw > longint'(clear_yaw))
                        begin
                            dir_seen = '0;
                            dir_only = '0;
                        end
                    end
                end
            end
            mog_pkg::ACT_CLEAR:
            begin
                dir_seen = '0;
                dir_only = '0;
            end
            default: ;
        endcase
        r.restrictions = dir_only;
        return r;
    endfunction

    // Predicts each accepted transaction and checks each delivered result.
    always @(posedge clk)
    begin : check_results
        mog_pkg::item_t taken;
        mog_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                taken.action = action;
                taken.vel_fwd = vel_fwd;
                taken.vel_side = vel_side;
                taken.vel_turn = vel_turn;
                taken.traj_valid = traj_valid;
                taken.pose_x = pose_x;
                taken.pose_y = pose_y;
                taken.pose_yaw = pose_yaw;
                want = guard_verdict(taken);
                if (want.oscillation_found)
                    latch_count = latch_count + 1;
                if (want.cost == mog_pkg::COST_PENALTY)
                    penalty_count = penalty_count + 1;
                pending_verdicts.push_back(want);
                items_taken = items_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                results_seen = results_seen + 1;
                if (pending_verdicts.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (cost !== want.cost)
                        report_mismatch("cost", int'(cost), int'(want.cost));
                    if (oscillation_found !== want.oscillation_found)
                        report_mismatch("oscillation_found", int'(oscillation_found),
                                        int'(want.oscillation_found));
                    if (restrictions !== want.restrictions)
                        report_mismatch("restrictions", int'(restrictions),
                                        int'(want.restrictions));
                end
            end
        end
    end

    // Drives one transaction and returns at the edge where it is accepted.
    task automatic send_item(input mog_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        in_valid <= 1'b1;
        action <= it.action;
        vel_fwd <= it.vel_fwd;
        vel_side <= it.vel_side;
        vel_turn <= it.vel_turn;
        traj_valid <= it.traj_valid;
        pose_x <= it.pose_x;
        pose_y <= it.pose_y;
        pose_yaw <= it.pose_yaw;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only with the guard idle.
    task automatic write_register(input logic [1:0] idx, input int unsigned value);
        wait_for_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[19:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        // Wait until the written value has reached the configuration register.
        @(posedge clk);
        case (idx)
            mog_pkg::CFG_SLOW_SPEED:     gate_speed = value[14:0];
            mog_pkg::CFG_RESET_DISTANCE: clear_radius = value[19:0];
            mog_pkg::CFG_RESET_ANGLE:    clear_yaw = value[14:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input int unsigned speed, input int unsigned radius,
                              input int unsigned ang);
        write_register(mog_pkg::CFG_SLOW_SPEED, speed);
        write_register(mog_pkg::CFG_RESET_DISTANCE, radius);
        write_register(mog_pkg::CFG_RESET_ANGLE, ang);
        settings_used = settings_used + 1;
    endtask

    function automatic mog_pkg::item_t mk_item(input logic [1:0] act, input int vf,
                                               input int vs, input int vt, input int tv,
                                               input int px, input int py,
                                               input int pyaw);
        mog_pkg::item_t it;
        it.action = act;
        it.vel_fwd = 16'(vf);
        it.vel_side = 16'(vs);
        it.vel_turn = 16'(vt);
        it.traj_valid = tv[0];
        it.pose_x = 24'(px);
        it.pose_y = 24'(py);
        it.pose_yaw = 16'(pyaw);
        return it;
    endfunction

    // Mostly small velocities of either sign, sometimes zero or any 16-bit value.
    function automatic logic signed [15:0] rand_vel(input int unsigned span);
        int unsigned pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'sd0;
        if (pick == 1)
            return 16'($urandom());
        mag = (span == 0) ? 1 : int'($urandom_range(1, span));
        return ($urandom_range(0, 1) == 1) ? 16'(mag) : 16'(-mag);
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Moves the walking pose: small steps, clear-limit edges and rare jumps.
    function automatic mog_pkg::item_t place_pose(input mog_pkg::item_t it);
        int stp;
        int ystp;
        int pick;
        stp = int'(clear_radius >> 1) + 3;
        ystp = int'(clear_yaw >> 1) + 3;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            walk_x = int'($urandom_range(0, 16777215)) - 8388608;
            walk_y = int'($urandom_range(0, 16777215)) - 8388608;
            walk_yaw = int'($urandom_range(0, 65535)) - 32768;
        end
        else if (pick == 1)
        begin
            // Right at the distance limit, or one step past it.
            walk_x = anchor_px;
            walk_x = walk_x + int'(clear_radius) + int'($urandom_range(0, 1));
            walk_y = anchor_py;
            walk_yaw = anchor_pyaw;
        end
        else if (pick == 2)
        begin
            // Right at the yaw limit, or one step past it.
            walk_x = anchor_px;
            walk_y = anchor_py;
            walk_yaw = anchor_pyaw;
            walk_yaw = walk_yaw - int'(clear_yaw) - int'($urandom_range(0, 1));
        end
        else
        begin
            walk_x = walk_x + int'($urandom_range(0, 2 * stp)) - stp;
            walk_y = walk_y + int'($urandom_range(0, 2 * stp)) - stp;
            walk_yaw = walk_yaw + int'($urandom_range(0, 2 * ystp)) - ystp;
        end
        walk_x = clamp(walk_x, -8388608, 8388607);
        walk_y = clamp(walk_y, -8388608, 8388607);
        walk_yaw = clamp(walk_yaw, -32768, 32767);
        it.pose_x = 24'(walk_x);
        it.pose_y = 24'(walk_y);
        it.pose_yaw = 16'(walk_yaw);
        return it;
    endfunction

    // Planner-like traffic: candidate scores and commits, some clears and noise.
    function automatic mog_pkg::item_t random_item();
        mog_pkg::item_t it;
        int unsigned roll;
        int unsigned fwd_span;
        it = '0;
        roll = $urandom_range(0, 99);
        fwd_span = gate_speed + (gate_speed >> 2) + 2;
        if (fwd_span > 32767)
            fwd_span = 32767;
        it.vel_fwd = rand_vel(fwd_span);
        it.vel_side = rand_vel(600);
        it.vel_turn = rand_vel(600);
        if (roll < 44)
        begin
            it.action = mog_pkg::ACT_SCORE;
        end
        else if (roll < 90)
        begin
            it.action = mog_pkg::ACT_COMMIT;
            it.traj_valid = ($urandom_range(0, 7) != 0);
            it = place_pose(it);
        end
        else if (roll < 94)
        begin
            it.action = mog_pkg::ACT_CLEAR;
        end
        else if (roll < 96)
        begin
            it.action = ACT_UNUSED;
            it.traj_valid = 1'($urandom_range(0, 1));
        end
        else
        begin
            it.action = 2'($urandom());
            it.vel_fwd = 16'($urandom());
            it.vel_side = 16'($urandom());
            it.vel_turn = 16'($urandom());
            it.traj_valid = 1'($urandom());
            it.pose_x = 24'($urandom());
            it.pose_y = 24'($urandom());
            it.pose_yaw = 16'($urandom());
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_item(random_item());
    endtask

    // Field extremes, every action and each corner of the flag and clear logic.
    task automatic test_directed();
        send_item(mk_item(mog_pkg::ACT_SCORE, -32768, 32767, -32768, 0, 0, 0, 0));
        send_item(mk_item(mog_pkg::ACT_COMMIT, 100, 300, -200, 1, 0, 0, 0));
        // All three axes reverse at once.
        send_item(mk_item(mog_pkg::ACT_COMMIT, -100, -300, 200, 1, 10, 10, 10));
        send_item(mk_item(mog_pkg::ACT_SCORE, 5, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(mog_pkg::ACT_SCORE, -5, -5, 5, 0, 0, 0, 0));
        send_item(mk_item(mog_pkg::ACT_SCORE, 0, 1, 0, 0, 0, 0, 0));
        send_item(mk_item(mog_pkg::ACT_SCORE, 0, 0, -1, 0, 0, 0, 0));
        // A commit without a valid trajectory changes nothing.
        send_item(mk_item(mog_pkg::ACT_COMMIT, 9, -9, 9, 0, 8388607, -8388608, 32767));
        // Exactly at the distance limit, then exactly at the yaw limit.
        send_item(mk_item(mog_pkg::ACT_COMMIT, 0, 0, 0, 1, 215, 10, 10));
        send_item(mk_item(mog_pkg::ACT_COMMIT, 0, 0, 0, 1, 10, 10, 829));
        send_item(mk_item(mog_pkg::ACT_COMMIT, 0, 0, 0, 1, 10, 10, -810));
        // Too fast for the sideways and turn axes to be tracked.
        send_item(mk_item(mog_pkg::ACT_COMMIT, 411, 5, 5, 1, 0, 0, 0));
        send_item(mk_item(mog_pkg::ACT_COMMIT, -32768, -5, -5, 1, 100, 100, -100));
        send_item(mk_item(mog_pkg::ACT_SCORE, 32767, 0, 0, 0, 0, 0, 0));
        // Clearing keeps the anchor.
        send_item(mk_item(mog_pkg::ACT_CLEAR, 1, 1, 1, 1, 5, 5, 5));
        send_item(mk_item(mog_pkg::ACT_COMMIT, 1, 32767, -32768, 1, 8388607, -8388608,
                          32767));
        send_item(mk_item(mog_pkg::ACT_COMMIT, -1, -1, 1, 1, -8388608, 8388607, -32768));
        send_item(mk_item(mog_pkg::ACT_COMMIT, 7, 0, 0, 1, -8388608, 8388607, -32768));
        send_item(mk_item(mog_pkg::ACT_SCORE, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(mog_pkg::ACT_SCORE, -3, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(ACT_UNUSED, -1, -1, -1, 1, -1, -1, -1));
        // One step past the distance limit clears everything.
        send_item(mk_item(mog_pkg::ACT_COMMIT, 0, 0, 0, 1, -8388402, 8388607, -32768));
        wait_for_results();
    endtask

    task automatic test_reset_limits();
        run_random(400);
    endtask

    // Every movement clears, and only a standing robot tracks side and turn.
    task automatic test_tight_limits();
        set_limits(0, 0, 0);
        run_random(300);
    endtask

    task automatic test_wide_limits();
        set_limits(32767, 1048575, 32767);
        run_random(300);
    endtask

    task automatic test_mixed_limits();
        repeat (4)
        begin
            set_limits($urandom_range(0, 2000), $urandom_range(0, 4000),
                       $urandom_range(0, 3000));
            run_random(200);
        end
    endtask

    // Back-to-back transactions with the receiver always ready.
    task automatic test_full_rate();
        set_limits(410, 205, 819);
        stall_enable = 1'b0;
        gap_max = 0;
        run_random(150);
        wait_for_results();
        stall_enable = 1'b1;
        gap_max = 8;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_reset_limits();
        test_tight_limits();
        test_wide_limits();
        test_mixed_limits();
        test_full_rate();
        wait_for_results();
        if (pending_verdicts.size() != 0)
            report_mismatch("results left over", 0, pending_verdicts.size());
        repeat (10) @(posedge clk);
        $display("Sent %0d transactions and checked %0d results under %0d register settings.",
                 items_taken, results_seen, settings_used);
        $display("Saw %0d restriction latches and %0d penalized candidates.",
                 latch_count, penalty_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
